FILE: src/sha2s_pkg.sv
// Package with SHA-224/SHA-256 constants, state codes and helper functions.
package sha2s_pkg;

    localparam logic [255:0] IV_224 = {
        32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
        32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4};
    localparam logic [255:0] IV_256 = {
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

    localparam logic [1:0] REG_DIGEST_MODE = 2'd0;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ROUND  = 3'd1;
    localparam logic [2:0] ST_ADD    = 3'd2;
    localparam logic [2:0] ST_PAD    = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k [0:63];
        k = '{
            32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
            32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
            32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
            32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
            32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
            32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
            32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
            32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
            32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
            32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
            32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
            32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
            32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
            32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
            32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
            32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};
        return k[t];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] iv_word(input logic mode, input logic [2:0] i);
        logic [255:0] iv;
        iv = mode ? IV_256 : IV_224;
        return iv[255 - 32 * i -: 32];
    endfunction

endpackage

FILE: src/sha224_sha256_stream_hasher.sv
// SHA-224/SHA-256 streaming hasher with one shared round unit.
//
// Channel   Direction  Content
// s_axis    in         tdata = data_byte, tuser = kind
// m_axis    out        tdata = digest_word, tuser = word_index, tlast = last_word
// apb       in         digest_mode at address 0
//
// A byte request is taken while the hasher is idle; the one that fills a block then
// runs the rounds and one chaining add on the single round unit, with s_tready low.
// A finish request pads, runs one or two compressions, then emits 7 or 8 words,
// one per cycle while m_tready is high. Reset is synchronous and active low.
module sha224_sha256_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // digest_word[31:0]
    output logic [2:0]  m_tuser,   // word_index[2:0]
    output logic        m_tlast,   // last_word
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [2:0]  state_reg;
    logic        mode_reg;
    logic [60:0] count_reg;
    logic [31:0] blk_reg [0:15];
    logic [31:0] win_reg [0:15];
    logic [31:0] h_reg [0:7];
    logic [31:0] v_reg [0:7];
    logic [5:0]  t_reg;
    logic        final_reg;
    logic        second_reg;
    logic [2:0]  oidx_reg;

    logic        cfg_wr;
    logic        s_acc;
    logic [5:0]  off;
    logic [31:0] wt, x15, x2, s0, s1, t1, t2, e_sig, a_sig, ch, maj;
    logic [63:0] bits;

    assign pready   = 1'b1;
    assign prdata   = {31'd0, mode_reg};
    assign cfg_wr   = psel && penable && pwrite && (paddr == sha2s_pkg::REG_DIGEST_MODE);
    assign s_tready = (state_reg == sha2s_pkg::ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign off      = count_reg[5:0];
    assign bits     = {count_reg, 3'b000};

    assign x15 = win_reg[4'(t_reg - 6'd15)];
    assign x2  = win_reg[4'(t_reg - 6'd2)];
    assign s0  = sha2s_pkg::rotr(x15, 7) ^ sha2s_pkg::rotr(x15, 18) ^ (x15 >> 3);
    assign s1  = sha2s_pkg::rotr(x2, 17) ^ sha2s_pkg::rotr(x2, 19) ^ (x2 >> 10);
    assign wt  = (t_reg < 6'd16) ? win_reg[t_reg[3:0]]
               : win_reg[t_reg[3:0]] + s0 + win_reg[4'(t_reg - 6'd7)] + s1;
    assign e_sig = sha2s_pkg::rotr(v_reg[4], 6) ^ sha2s_pkg::rotr(v_reg[4], 11)
                 ^ sha2s_pkg::rotr(v_reg[4], 25);
    assign a_sig = sha2s_pkg::rotr(v_reg[0], 2) ^ sha2s_pkg::rotr(v_reg[0], 13)
                 ^ sha2s_pkg::rotr(v_reg[0], 22);
    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1  = v_reg[7] + e_sig + ch + sha2s_pkg::round_k(t_reg) + wt;
    assign t2  = a_sig + maj;

    assign m_tvalid = (state_reg == sha2s_pkg::ST_OUT);
    assign m_tdata  = h_reg[oidx_reg];
    assign m_tuser  = oidx_reg;
    assign m_tlast  = mode_reg ? (oidx_reg == 3'd7) : (oidx_reg == 3'd6);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= sha2s_pkg::ST_IDLE;
            mode_reg   <= 1'b1;
            count_reg  <= '0;
            t_reg      <= '0;
            final_reg  <= 1'b0;
            second_reg <= 1'b0;
            oidx_reg   <= '0;
            for (int i = 0; i < 8; i++) h_reg[i] <= sha2s_pkg::iv_word(1'b1, 3'(i));
        end else begin
            if (cfg_wr) begin
                mode_reg  <= pwdata[0];
                count_reg <= '0;
                for (int i = 0; i < 8; i++) h_reg[i] <= sha2s_pkg::iv_word(pwdata[0], 3'(i));
            end
            case (state_reg)
                sha2s_pkg::ST_IDLE: begin
                    if (s_acc && !s_tuser) begin
                        blk_reg[off[5:2]][8 * (3 - off[1:0]) +: 8] <= s_tdata;
                        count_reg <= count_reg + 61'd1;
                        if (off == 6'd63) begin
                            for (int i = 0; i < 15; i++) win_reg[i] <= blk_reg[i];
                            win_reg[15] <= {blk_reg[15][31:8], s_tdata};
                            for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                            t_reg     <= '0;
                            final_reg <= 1'b0;
                            state_reg <= sha2s_pkg::ST_ROUND;
                        end
                    end else if (s_acc) begin
                        for (int i = 0; i < 64; i++) begin
                            if (6'(i) == off)
                                blk_reg[4'(i / 4)][8 * (3 - i % 4) +: 8] <= sha2s_pkg::PAD_BYTE;
                            else if (6'(i) > off)
                                blk_reg[4'(i / 4)][8 * (3 - i % 4) +: 8] <= 8'd0;
                        end
                        final_reg  <= 1'b1;
                        second_reg <= (off >= sha2s_pkg::LEN_OFFSET);
                        state_reg  <= sha2s_pkg::ST_PAD;
                    end
                end
                sha2s_pkg::ST_PAD: begin
                    for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                    t_reg <= '0;
                    if (second_reg) begin
                        for (int i = 0; i < 16; i++) win_reg[i] <= blk_reg[i];
                        for (int i = 0; i < 16; i++) blk_reg[i] <= '0;
                    end else begin
                        for (int i = 0; i < 14; i++) win_reg[i] <= blk_reg[i];
                        win_reg[14] <= bits[63:32];
                        win_reg[15] <= bits[31:0];
                    end
                    state_reg <= sha2s_pkg::ST_ROUND;
                end
                sha2s_pkg::ST_ROUND: begin
                    if (t_reg >= 6'd16) win_reg[t_reg[3:0]] <= wt;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    t_reg <= t_reg + 6'd1;
                    if (t_reg == 6'd63) state_reg <= sha2s_pkg::ST_ADD;
                end
                sha2s_pkg::ST_ADD: begin
                    for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                    if (!final_reg) begin
                        state_reg <= sha2s_pkg::ST_IDLE;
                    end else if (second_reg) begin
                        second_reg <= 1'b0;
                        state_reg  <= sha2s_pkg::ST_PAD;
                    end else begin
                        oidx_reg  <= '0;
                        state_reg <= sha2s_pkg::ST_OUT;
                    end
                end
                sha2s_pkg::ST_OUT: begin
                    if (m_tready) begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (m_tlast) begin
                            count_reg <= '0;
                            final_reg <= 1'b0;
                            for (int i = 0; i < 8; i++)
                                h_reg[i] <= sha2s_pkg::iv_word(mode_reg, 3'(i));
                            state_reg <= sha2s_pkg::ST_IDLE;
                        end
                    end
                end
                default: state_reg <= sha2s_pkg::ST_IDLE;
            endcase
        end
    end

endmodule
